>>> src/pvp_pkg.sv
// Shared widths, register codes and payload types of the vertex projection core.
package pvp_pkg;

   localparam int COORD_WIDTH     = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int COEF_WIDTH      = 16;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int SCALE_WIDTH     = 16;
   localparam int LANES           = 2;

   // coefficient pair product, rounded back to COEF_FRAC_BITS fraction bits
   localparam int PROD_WIDTH      = 2 * COEF_WIDTH + 1;
   localparam int PAIR_WIDTH      = PROD_WIDTH - COEF_FRAC_BITS;

   // view coordinates; clamp limit is +-(2^46 - 1)
   localparam int VIEW_SUM_WIDTH  = COORD_WIDTH + PAIR_WIDTH + 2;
   localparam int VIEW_LIMIT_BITS = 46;
   localparam int VIEW_WIDTH      = (VIEW_SUM_WIDTH < VIEW_LIMIT_BITS + 1) ?
                                    VIEW_SUM_WIDTH : VIEW_LIMIT_BITS + 1;

   // divider: magnitude of scale * view over a positive depth
   localparam int NUM_WIDTH       = VIEW_WIDTH + SCALE_WIDTH;
   localparam int DEN_WIDTH       = VIEW_WIDTH - 1;
   localparam int QUOT_WIDTH      = ((COORD_WIDTH > CSR_DATA_WIDTH) ?
                                     COORD_WIDTH : CSR_DATA_WIDTH) + 1;
   localparam int DIV_STAGES      = QUOT_WIDTH + 1;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COS_YAW       = 3'd0,
      CSR_SIN_YAW       = 3'd1,
      CSR_COS_PITCH     = 3'd2,
      CSR_SIN_PITCH     = 3'd3,
      CSR_VIEW_DISTANCE = 3'd4,
      CSR_PROJ_SCALE    = 3'd5,
      CSR_SCREEN_OFF_X  = 3'd6,
      CSR_SCREEN_OFF_Y  = 3'd7
   } csr_index_type;

   localparam logic [CSR_DATA_WIDTH-1:0] RST_COS_YAW       = CSR_DATA_WIDTH'(15396);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_SIN_YAW       = CSR_DATA_WIDTH'(5604);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_COS_PITCH     = CSR_DATA_WIDTH'(-12551);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_SIN_PITCH     = CSR_DATA_WIDTH'(10531);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_VIEW_DISTANCE = CSR_DATA_WIDTH'(1000);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_PROJ_SCALE    = CSR_DATA_WIDTH'(800);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_SCREEN_OFF_X  = CSR_DATA_WIDTH'(400);
   localparam logic [CSR_DATA_WIDTH-1:0] RST_SCREEN_OFF_Y  = CSR_DATA_WIDTH'(400);

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] world_x;
      logic signed [COORD_WIDTH-1:0] world_y;
      logic signed [COORD_WIDTH-1:0] world_z;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] screen_x;
      logic signed [COORD_WIDTH-1:0] screen_y;
      logic                          behind_eye;
   } rsp_payload_type;

   typedef struct packed {
      logic [LANES-1:0][NUM_WIDTH-1:0] num_mag;
      logic [LANES-1:0]                neg;
      logic [DEN_WIDTH-1:0]            den;
      logic                            behind;
   } div_in_type;

   typedef struct packed {
      logic [LANES-1:0][QUOT_WIDTH-1:0] quot_mag;
      logic [LANES-1:0]                 ovf;
      logic [LANES-1:0]                 neg;
      logic                             behind;
   } div_out_type;

endpackage

>>> src/pvp_div.sv
// Pipelined restoring divider: an overflow-test stage, then one quotient bit per stage, two lanes sharing the divisor.
module pvp_div (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic                 in_valid,
   input  pvp_pkg::div_in_type  in_data,
   output logic                 out_valid,
   output pvp_pkg::div_out_type out_data
);
   import pvp_pkg::*;

   logic                             valid_ff  [DIV_STAGES];
   logic [LANES-1:0][NUM_WIDTH-1:0]  rem_ff    [DIV_STAGES];
   logic [LANES-1:0][QUOT_WIDTH-1:0] quot_ff   [DIV_STAGES];
   logic [LANES-1:0]                 ovf_ff    [DIV_STAGES];
   logic [LANES-1:0]                 neg_ff    [DIV_STAGES];
   logic [DEN_WIDTH-1:0]             den_ff    [DIV_STAGES];
   logic                             behind_ff [DIV_STAGES];

   logic                             src_valid  [DIV_STAGES];
   logic [LANES-1:0][NUM_WIDTH-1:0]  src_rem    [DIV_STAGES];
   logic [LANES-1:0][QUOT_WIDTH-1:0] src_quot   [DIV_STAGES];
   logic [LANES-1:0]                 src_ovf    [DIV_STAGES];
   logic [LANES-1:0]                 src_neg    [DIV_STAGES];
   logic [DEN_WIDTH-1:0]             src_den    [DIV_STAGES];
   logic                             src_behind [DIV_STAGES];

   logic [LANES-1:0][NUM_WIDTH-1:0]  rem_in  [DIV_STAGES];
   logic [LANES-1:0][QUOT_WIDTH-1:0] quot_in [DIV_STAGES];
   logic [LANES-1:0]                 ovf_in  [DIV_STAGES];

   always_comb begin
      src_valid[0]  = in_valid;
      src_rem[0]    = in_data.num_mag;
      src_quot[0]   = '0;
      src_ovf[0]    = '0;
      src_neg[0]    = in_data.neg;
      src_den[0]    = in_data.den;
      src_behind[0] = in_data.behind;
      for (int s = 1; s < DIV_STAGES; s++) begin
         src_valid[s]  = valid_ff[s-1];
         src_rem[s]    = rem_ff[s-1];
         src_quot[s]   = quot_ff[s-1];
         src_ovf[s]    = ovf_ff[s-1];
         src_neg[s]    = neg_ff[s-1];
         src_den[s]    = den_ff[s-1];
         src_behind[s] = behind_ff[s-1];
      end
   end

   // first stage only tests for a quotient that does not fit QUOT_WIDTH bits
   always_comb begin
      int                   pos;
      logic [NUM_WIDTH:0]   diff;
      logic                 ge;
      logic [NUM_WIDTH-1:0] low_mask;
      pos      = 0;
      diff     = '0;
      ge       = 1'b0;
      low_mask = '0;
      for (int s = 0; s < DIV_STAGES; s++) begin
         pos        = QUOT_WIDTH - s;
         low_mask   = (NUM_WIDTH'(1) << pos) - NUM_WIDTH'(1);
         rem_in[s]  = src_rem[s];
         quot_in[s] = src_quot[s];
         ovf_in[s]  = src_ovf[s];
         for (int l = 0; l < LANES; l++) begin
            diff = {1'b0, src_rem[s][l] >> pos} - (NUM_WIDTH + 1)'(src_den[s]);
            ge   = ~diff[NUM_WIDTH];
            if (s == 0) begin
               ovf_in[s][l] = ge;
            end else if (ge) begin
               rem_in[s][l]  = (diff[NUM_WIDTH-1:0] << pos) | (src_rem[s][l] & low_mask);
               quot_in[s][l] = src_quot[s][l] | (QUOT_WIDTH'(1) << pos);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (advance) begin
            valid_ff[s] <= src_valid[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            rem_ff[s]    <= rem_in[s];
            quot_ff[s]   <= quot_in[s];
            ovf_ff[s]    <= ovf_in[s];
            neg_ff[s]    <= src_neg[s];
            den_ff[s]    <= src_den[s];
            behind_ff[s] <= src_behind[s];
         end
      end
   end

   assign out_valid         = valid_ff[DIV_STAGES-1];
   assign out_data.quot_mag = quot_ff[DIV_STAGES-1];
   assign out_data.ovf      = ovf_ff[DIV_STAGES-1];
   assign out_data.neg      = neg_ff[DIV_STAGES-1];
   assign out_data.behind   = behind_ff[DIV_STAGES-1];

endmodule

>>> src/perspective_vertex_projection_core.sv
// Top level: view rotation, depth offset and perspective divide of one vertex per beat.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_data  (world_x, world_y, world_z)
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_data  (screen_x, screen_y, behind_eye)
//   csr     | in        | csr_we               | csr_index, csr_wdata
//
// One vertex per cycle sustained while the skid register is empty; rsp_valid rises once a beat
// has passed six input/multiply/sum/abs stages, the 18-stage divider and the output register.
// Pipeline advances while the skid register is empty; req_ready is that registered flag,
// so a beat is still taken while a result waits on rsp.
// Synchronous reset clears valid bits and loads the register defaults.
module perspective_vertex_projection_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  pvp_pkg::req_payload_type             req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output pvp_pkg::rsp_payload_type             rsp_data,
   input  logic                                 csr_we,
   input  logic [pvp_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [pvp_pkg::CSR_DATA_WIDTH-1:0]   csr_wdata
);
   import pvp_pkg::*;

   localparam int MUL1_WIDTH = COORD_WIDTH + COEF_WIDTH;
   localparam int MUL2_WIDTH = COORD_WIDTH + PAIR_WIDTH;
   localparam int SUM_WIDTH  = QUOT_WIDTH + 2;
   localparam logic signed [PROD_WIDTH-1:0] ROUND_HALF =
      PROD_WIDTH'(longint'(1) <<< (COEF_FRAC_BITS - 1));
   localparam logic signed [63:0] VIEW_MAX = (64'sd1 <<< VIEW_LIMIT_BITS) - 64'sd1;
   localparam logic signed [SUM_WIDTH-1:0] COORD_MAX =
      SUM_WIDTH'((longint'(1) <<< (COORD_WIDTH - 1)) - longint'(1));
   localparam logic signed [SUM_WIDTH-1:0] COORD_MIN =
      SUM_WIDTH'(-(longint'(1) <<< (COORD_WIDTH - 1)));

   function automatic logic signed [PAIR_WIDTH-1:0] pair_round(
      input logic signed [COEF_WIDTH-1:0] a,
      input logic signed [COEF_WIDTH-1:0] b
   );
      logic signed [PROD_WIDTH-1:0] p;
      p = PROD_WIDTH'(a) * PROD_WIDTH'(b);
      p = p + ROUND_HALF;
      return PAIR_WIDTH'(p >>> COEF_FRAC_BITS);
   endfunction

   function automatic logic signed [VIEW_WIDTH-1:0] clamp_view(
      input logic signed [VIEW_SUM_WIDTH-1:0] v
   );
      logic signed [63:0] w;
      w = 64'(v);
      if (w > VIEW_MAX) begin
         w = VIEW_MAX;
      end else if (w < -VIEW_MAX) begin
         w = -VIEW_MAX;
      end
      return VIEW_WIDTH'(w);
   endfunction

   // configuration registers
   logic signed [COEF_WIDTH-1:0]     cos_yaw_ff, sin_yaw_ff, cos_pitch_ff, sin_pitch_ff;
   logic signed [CSR_DATA_WIDTH-1:0] view_distance_ff, screen_off_x_ff, screen_off_y_ff;
   logic [SCALE_WIDTH-1:0]           proj_scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cos_yaw_ff       <= RST_COS_YAW;
         sin_yaw_ff       <= RST_SIN_YAW;
         cos_pitch_ff     <= RST_COS_PITCH;
         sin_pitch_ff     <= RST_SIN_PITCH;
         view_distance_ff <= RST_VIEW_DISTANCE;
         proj_scale_ff    <= RST_PROJ_SCALE;
         screen_off_x_ff  <= RST_SCREEN_OFF_X;
         screen_off_y_ff  <= RST_SCREEN_OFF_Y;
      end else if (csr_we) begin
         case (csr_index)
            CSR_COS_YAW:       cos_yaw_ff       <= csr_wdata;
            CSR_SIN_YAW:       sin_yaw_ff       <= csr_wdata;
            CSR_COS_PITCH:     cos_pitch_ff     <= csr_wdata;
            CSR_SIN_PITCH:     sin_pitch_ff     <= csr_wdata;
            CSR_VIEW_DISTANCE: view_distance_ff <= csr_wdata;
            CSR_PROJ_SCALE:    proj_scale_ff    <= csr_wdata;
            CSR_SCREEN_OFF_X:  screen_off_x_ff  <= csr_wdata;
            CSR_SCREEN_OFF_Y:  screen_off_y_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // coefficient pairs, recomputed every cycle; read by the stage 2 products
   logic signed [PAIR_WIDTH-1:0] pair_sasb_ff, pair_casb_ff, pair_sacb_ff, pair_cacb_ff;

   always_ff @(posedge clock) begin
      pair_sasb_ff <= pair_round(sin_yaw_ff, sin_pitch_ff);
      pair_casb_ff <= pair_round(cos_yaw_ff, sin_pitch_ff);
      pair_sacb_ff <= pair_round(sin_yaw_ff, cos_pitch_ff);
      pair_cacb_ff <= pair_round(cos_yaw_ff, cos_pitch_ff);
   end

   // flow control
   logic advance;
   logic skid_valid_ff, rsp_valid_ff;

   assign advance   = ~skid_valid_ff;
   assign req_ready = advance;

   // stage 0: input register
   logic                          v0_ff;
   logic signed [COORD_WIDTH-1:0] x0_ff, y0_ff, z0_ff;

   // stage 1: products with single coefficients
   logic                          v1_ff;
   logic signed [COORD_WIDTH-1:0] x1_ff, z1_ff;
   logic signed [MUL1_WIDTH-1:0]  xca1_ff, zsa1_ff, ycb1_ff, ysb1_ff;

   // stage 2: products with coefficient pairs
   logic                          v2_ff;
   logic signed [MUL1_WIDTH-1:0]  xca2_ff, zsa2_ff, ycb2_ff, ysb2_ff;
   logic signed [MUL2_WIDTH-1:0]  xsasb2_ff, zcasb2_ff, xsacb2_ff, zcacb2_ff;

   // stage 3: view coordinates
   logic                          v3_ff;
   logic signed [VIEW_WIDTH-1:0]  view3_ff [LANES];
   logic signed [VIEW_WIDTH-1:0]  vz3_ff;
   logic signed [VIEW_SUM_WIDTH-1:0] vx_sum, vy_sum, vz_sum;

   // stage 4: numerators
   logic                          v4_ff;
   logic signed [NUM_WIDTH:0]     num4_ff [LANES];
   logic [DEN_WIDTH-1:0]          den4_ff;
   logic                          behind4_ff;

   // stage 5: magnitudes into the divider
   logic                          v5_ff;
   div_in_type                    div5_ff;
   div_in_type                    div5_in;

   assign vx_sum = VIEW_SUM_WIDTH'(xca2_ff) - VIEW_SUM_WIDTH'(zsa2_ff);
   assign vy_sum = VIEW_SUM_WIDTH'(xsasb2_ff) + VIEW_SUM_WIDTH'(ycb2_ff)
                 + VIEW_SUM_WIDTH'(zcasb2_ff);
   assign vz_sum = VIEW_SUM_WIDTH'(xsacb2_ff) - VIEW_SUM_WIDTH'(ysb2_ff)
                 + VIEW_SUM_WIDTH'(zcacb2_ff)
                 + (VIEW_SUM_WIDTH'(view_distance_ff) <<< COEF_FRAC_BITS);

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         div5_in.num_mag[l] = NUM_WIDTH'(num4_ff[l][NUM_WIDTH] ? -num4_ff[l] : num4_ff[l]);
         div5_in.neg[l]     = num4_ff[l][NUM_WIDTH];
      end
      div5_in.den    = den4_ff;
      div5_in.behind = behind4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff      <= req_data.world_x;
         y0_ff      <= req_data.world_y;
         z0_ff      <= req_data.world_z;

         x1_ff      <= x0_ff;
         z1_ff      <= z0_ff;
         xca1_ff    <= MUL1_WIDTH'(x0_ff) * MUL1_WIDTH'(cos_yaw_ff);
         zsa1_ff    <= MUL1_WIDTH'(z0_ff) * MUL1_WIDTH'(sin_yaw_ff);
         ycb1_ff    <= MUL1_WIDTH'(y0_ff) * MUL1_WIDTH'(cos_pitch_ff);
         ysb1_ff    <= MUL1_WIDTH'(y0_ff) * MUL1_WIDTH'(sin_pitch_ff);

         xca2_ff    <= xca1_ff;
         zsa2_ff    <= zsa1_ff;
         ycb2_ff    <= ycb1_ff;
         ysb2_ff    <= ysb1_ff;
         xsasb2_ff  <= MUL2_WIDTH'(x1_ff) * MUL2_WIDTH'(pair_sasb_ff);
         zcasb2_ff  <= MUL2_WIDTH'(z1_ff) * MUL2_WIDTH'(pair_casb_ff);
         xsacb2_ff  <= MUL2_WIDTH'(x1_ff) * MUL2_WIDTH'(pair_sacb_ff);
         zcacb2_ff  <= MUL2_WIDTH'(z1_ff) * MUL2_WIDTH'(pair_cacb_ff);

         view3_ff[0] <= clamp_view(vx_sum);
         view3_ff[1] <= clamp_view(vy_sum);
         vz3_ff      <= clamp_view(vz_sum);

         for (int l = 0; l < LANES; l++) begin
            num4_ff[l] <= (NUM_WIDTH + 1)'($signed({1'b0, proj_scale_ff}))
                        * (NUM_WIDTH + 1)'(view3_ff[l]);
         end
         den4_ff    <= vz3_ff[DEN_WIDTH-1:0];
         behind4_ff <= vz3_ff[VIEW_WIDTH-1] || (vz3_ff == '0);

         div5_ff    <= div5_in;
      end
   end

   // divider
   logic        div_valid;
   div_out_type div_out;

   pvp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v5_ff),
      .in_data   (div5_ff),
      .out_valid (div_valid),
      .out_data  (div_out)
   );

   // sign, offset and saturation
   logic signed [CSR_DATA_WIDTH-1:0] offset [LANES];
   logic signed [COORD_WIDTH-1:0]    lane_screen [LANES];
   rsp_payload_type                  exit_data;
   logic                             exit_valid;

   assign offset[0] = screen_off_x_ff;
   assign offset[1] = screen_off_y_ff;

   always_comb begin
      logic [QUOT_WIDTH-1:0]       mag;
      logic signed [SUM_WIDTH-1:0] quot;
      logic signed [SUM_WIDTH-1:0] sum;
      logic signed [SUM_WIDTH-1:0] clipped;
      mag     = '0;
      quot    = '0;
      sum     = '0;
      clipped = '0;
      for (int l = 0; l < LANES; l++) begin
         mag  = div_out.ovf[l] ? '1 : div_out.quot_mag[l];
         quot = $signed(SUM_WIDTH'(mag));
         if (div_out.neg[l]) begin
            quot = -quot;
         end
         sum = quot + SUM_WIDTH'(offset[l]);
         if (sum > COORD_MAX) begin
            clipped = COORD_MAX;
         end else if (sum < COORD_MIN) begin
            clipped = COORD_MIN;
         end else begin
            clipped = sum;
         end
         lane_screen[l] = div_out.behind ? '0 : COORD_WIDTH'(clipped);
      end
   end

   assign exit_data.screen_x   = lane_screen[0];
   assign exit_data.screen_y   = lane_screen[1];
   assign exit_data.behind_eye = div_out.behind;
   assign exit_valid           = div_valid & advance;

   // output register plus skid register
   logic            rsp_valid_in, skid_valid_in;
   logic            rsp_load, skid_load;
   rsp_payload_type rsp_data_ff, skid_data_ff, rsp_data_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      rsp_load      = 1'b0;
      skid_load     = 1'b0;
      rsp_data_in   = exit_data;
      if (rsp_valid_ff && !rsp_ready) begin
         if (exit_valid) begin
            skid_valid_in = 1'b1;
            skid_load     = 1'b1;
         end
      end else if (skid_valid_ff) begin
         rsp_valid_in  = 1'b1;
         skid_valid_in = 1'b0;
         rsp_load      = 1'b1;
         rsp_data_in   = skid_data_ff;
      end else begin
         rsp_valid_in = exit_valid;
         rsp_load     = exit_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
      if (skid_load) begin
         skid_data_ff <= exit_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   // skid only holds a beat while the output register is occupied
   a_skid_behind_rsp : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while output register empty");

   // skid fills only when the output was stalled
   a_skid_fill_on_stall : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid register filled without an output stall");

   // every accepted beat shows up in the first stage
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> v0_ff)
      else $error("accepted beat missing from the first stage");
`endif

endmodule
